// ----- rtl/psd_pkg.sv -----
// ----------------------------------------------------------------------------
// psd_pkg
// Types and constants of the gain-scheduled pid stepper position drive.
// ----------------------------------------------------------------------------
package psd_pkg;

  // drive constants
  localparam logic [15:0] MaxPulse  = 16'd2000;
  localparam logic [15:0] Accel     = 16'd10;
  localparam logic [9:0]  LowLimit  = 10'd0;
  localparam logic [9:0]  HighLimit = 10'd1023;
  localparam int unsigned AdcBits   = 10;

  localparam int unsigned SampleW = 10;
  localparam logic [SampleW-1:0] SampleMask =
    (AdcBits >= SampleW) ? {SampleW{1'b1}} : SampleW'((1 << AdcBits) - 1);

  localparam logic [9:0]  BigError     = 10'd30;
  localparam logic [2:0]  ArriveNeeded = 3'd5;
  localparam logic [2:0]  LastStep     = 3'd5;

  // speed saturates once |u| * 5000 / 512 reaches 1000
  localparam logic [12:0] SpeedScale = 13'd5000;
  localparam logic [9:0]  SpeedMax   = 10'd1000;
  localparam int          SpeedSatU  = 103;

  // divide by 1000 as multiply by ceil(2^36 / 1000), exact below 2^26
  localparam int unsigned RecipShift = 36;
  localparam logic [26:0] Recip1000  = 27'd68719477;

  localparam int unsigned MulW  = 28;
  localparam int unsigned ProdW = 2 * MulW;
  localparam int unsigned AccW  = 40;

  typedef enum logic [2:0] {
    CfgTarget   = 3'd0,
    CfgKp       = 3'd1,
    CfgKi       = 3'd2,
    CfgKd       = 3'd3,
    CfgIntLimit = 3'd4,
    CfgDeadband = 3'd5,
    CfgFastMin  = 3'd6,
    CfgSlowMin  = 3'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    StIdle,
    StPrep,
    StMulP,
    StMulI,
    StMulD,
    StSum,
    StCheck,
    StSpeed,
    StScale,
    StAbs,
    StDiv,
    StTarget,
    StStep,
    StOne
  } state_e;

endpackage

// ----- rtl/pid_stepper_position_drive.sv -----
// ----------------------------------------------------------------------------
// pid_stepper_position_drive
// Gain-scheduled pid position loop that turns position samples into
// ramped stepper pulse requests, built around one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis_* carries one position sample per request. For each sample the
//   block forms the error against target_value, updates the clamped integral
//   and runs the pid sum, speed and pulse target through one 28x28 multiplier
//   under a small sequencer.
//   A move gives six results on m_axis_*, one per step, tlast on the sixth;
//   a deadband or zero-control sample gives a single result with tlast.
//   s_axis_tready is high only while the sequencer is idle, so a new sample
//   waits until the multiplier chain is through with the last one and its
//   final result has entered the output register.
//   Results leave through an output register, so the next sample is accepted
//   while the last result still waits. A stalled receiver holds the sequencer
//   at the current step until the output register frees up.
//   Registers are written on cfg_* while the block is idle; cfg_ready_o is
//   high in idle and a pending write goes ahead of a sample. Reset (rst_ni
//   low) loads the register defaults, clears the loop state and sets the
//   pulse period to its maximum.
// ----------------------------------------------------------------------------
module pid_stepper_position_drive (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input samples
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [9:0] sample
  // step results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [15:0] high_time, [31:16] low_time,
                                      // [32] move_dir, [33] motor_enable,
                                      // [34] target_reached
  output logic [0:0]  m_axis_tuser,   // [0] step_fired
  output logic        m_axis_tlast,
  // register writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [19:0] cfg_data_i
);

  localparam int unsigned MulW  = psd_pkg::MulW;
  localparam int unsigned ProdW = psd_pkg::ProdW;
  localparam int unsigned AccW  = psd_pkg::AccW;

  psd_pkg::state_e state_q, state_d;

  // registers
  logic [9:0]  target_q;
  logic [15:0] kp_q, ki_q, kd_q;
  logic [19:0] ilim_q;
  logic [9:0]  deadband_q;
  logic [15:0] fast_q, slow_q;

  // loop state
  logic signed [21:0] int_q;
  logic signed [10:0] prev_q;
  logic [15:0]        pulse_q;
  logic               ramp_q;
  logic               enabled_q;
  logic [2:0]         arrive_q;
  logic               reached_q;

  // per-sample working registers
  logic [9:0]             sample_q;
  logic signed [10:0]     e_q;
  logic signed [11:0]     delta_q;
  logic                   big_q, db_q;
  logic [20:0]            pg_q;
  logic [16:0]            ig_q;
  logic [18:0]            dg_q;
  logic signed [AccW-1:0] acc_q;
  logic signed [ProdW-1:0] prod_q;
  logic                   dir_q, usat_q, neg_q;
  logic [9:0]             s_q;
  logic [25:0]            m_q;
  logic [15:0]            tgt_q;
  logic [2:0]             k_q;

  // output register
  logic        out_valid_q;
  logic        fired_q, odir_q, oen_q, oreach_q, olast_q;
  logic [15:0] high_q, low_q;

  logic in_fire, out_free, cfg_fire;
  // a pending register write goes first
  assign s_axis_tready = (state_q == psd_pkg::StIdle) && !cfg_valid_i;
  assign cfg_ready_o   = (state_q == psd_pkg::StIdle);
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign cfg_fire = cfg_valid_i && cfg_ready_o;
  assign out_free = !out_valid_q || m_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, oreach_q, oen_q, odir_q, low_q, high_q};
  assign m_axis_tuser  = fired_q;
  assign m_axis_tlast  = olast_q;

  // ---------------------------------------------------------------------------
  // combinational helpers
  // ---------------------------------------------------------------------------
  logic [9:0]         sample_in;
  logic signed [10:0] e_in;
  logic [9:0]         ae;
  logic signed [22:0] int_sum, lim_pos;
  logic signed [21:0] int_clamped;
  logic [6:0]         au7;
  logic               u_sat;
  logic [15:0]        minp;
  logic signed [17:0] pdiff;
  logic [15:0]        quo;
  logic signed [17:0] tgt_s;
  logic               blocked, is_last;
  logic [16:0]        up_p;
  logic signed [17:0] dn_p;
  logic [15:0]        pulse_nx;
  logic [2:0]         arrive_nx;
  logic               reached_nx;

  assign sample_in = s_axis_tdata[9:0] & psd_pkg::SampleMask;
  assign e_in = $signed({1'b0, target_q}) - $signed({1'b0, sample_in});
  assign ae   = e_q[10] ? 10'(-e_q) : e_q[9:0];

  assign int_sum = 23'(int_q) + 23'(e_q);
  assign lim_pos = $signed({3'd0, ilim_q});
  always_comb begin
    if (int_sum > lim_pos) begin
      int_clamped = lim_pos[21:0];
    end else if (int_sum < -lim_pos) begin
      int_clamped = 22'(-lim_pos);
    end else begin
      int_clamped = int_sum[21:0];
    end
  end

  // only the low bits of |u| matter below saturation
  assign au7   = acc_q[AccW-1] ? (~acc_q[6:0] + 7'd1) : acc_q[6:0];
  assign u_sat = (acc_q >= AccW'(psd_pkg::SpeedSatU)) ||
                 (acc_q <= -AccW'(psd_pkg::SpeedSatU));

  assign minp  = big_q ? fast_q : slow_q;
  assign pdiff = $signed({2'd0, minp}) - $signed({2'd0, psd_pkg::MaxPulse});

  assign quo   = prod_q[psd_pkg::RecipShift +: 16];
  assign tgt_s = $signed({2'd0, psd_pkg::MaxPulse}) +
                 (neg_q ? -$signed({2'd0, quo}) : $signed({2'd0, quo}));

  assign blocked = (dir_q && ({1'b0, sample_q} < {1'b0, psd_pkg::LowLimit})) ||
                   (!dir_q && ({1'b0, sample_q} > {1'b0, psd_pkg::HighLimit}));
  assign is_last = (k_q == psd_pkg::LastStep);

  // pulse ramp toward the target width, restarting at the maximum on a reversal
  assign up_p = {1'b0, pulse_q} + {1'b0, psd_pkg::Accel};
  assign dn_p = $signed({2'd0, pulse_q}) - $signed({2'd0, psd_pkg::Accel});
  always_comb begin
    if (dir_q != ramp_q) begin
      pulse_nx = psd_pkg::MaxPulse;
    end else if (pulse_q < tgt_q) begin
      pulse_nx = (up_p < {1'b0, tgt_q}) ? up_p[15:0] : tgt_q;
    end else if (pulse_q > tgt_q) begin
      pulse_nx = (dn_p > $signed({2'd0, tgt_q})) ? dn_p[15:0] : tgt_q;
    end else begin
      pulse_nx = pulse_q;
    end
  end

  assign arrive_nx  = (arrive_q < psd_pkg::ArriveNeeded) ? arrive_q + 3'd1 : arrive_q;
  assign reached_nx = reached_q || (arrive_nx >= psd_pkg::ArriveNeeded);

  // ---------------------------------------------------------------------------
  // shared multiplier
  // ---------------------------------------------------------------------------
  logic signed [MulW-1:0]  mul_a, mul_b;
  logic signed [ProdW-1:0] prod_d;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      psd_pkg::StMulP: begin
        mul_a = $signed(MulW'(pg_q));
        mul_b = MulW'(e_q);
      end
      psd_pkg::StMulI: begin
        mul_a = $signed(MulW'(ig_q));
        mul_b = MulW'(int_q);
      end
      psd_pkg::StMulD: begin
        mul_a = $signed(MulW'(dg_q));
        mul_b = MulW'(delta_q);
      end
      psd_pkg::StCheck: begin
        mul_a = $signed(MulW'(au7));
        mul_b = $signed(MulW'(psd_pkg::SpeedScale));
      end
      psd_pkg::StScale: begin
        mul_a = $signed(MulW'(s_q));
        mul_b = MulW'(pdiff);
      end
      psd_pkg::StDiv: begin
        mul_a = $signed(MulW'(m_q));
        mul_b = $signed(MulW'(psd_pkg::Recip1000));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= psd_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      psd_pkg::StIdle:   if (in_fire) state_d = psd_pkg::StPrep;
      psd_pkg::StPrep:   state_d = psd_pkg::StMulP;
      psd_pkg::StMulP:   state_d = psd_pkg::StMulI;
      psd_pkg::StMulI:   state_d = psd_pkg::StMulD;
      psd_pkg::StMulD:   state_d = psd_pkg::StSum;
      psd_pkg::StSum:    state_d = psd_pkg::StCheck;
      psd_pkg::StCheck: begin
        if (db_q || acc_q == '0) begin
          state_d = psd_pkg::StOne;
        end else begin
          state_d = psd_pkg::StSpeed;
        end
      end
      psd_pkg::StSpeed:  state_d = psd_pkg::StScale;
      psd_pkg::StScale:  state_d = psd_pkg::StAbs;
      psd_pkg::StAbs:    state_d = psd_pkg::StDiv;
      psd_pkg::StDiv:    state_d = psd_pkg::StTarget;
      psd_pkg::StTarget: state_d = psd_pkg::StStep;
      psd_pkg::StStep:   if (out_free && is_last) state_d = psd_pkg::StIdle;
      psd_pkg::StOne:    if (out_free) state_d = psd_pkg::StIdle;
      default:           state_d = psd_pkg::StIdle;
    endcase
  end

  // ---------------------------------------------------------------------------
  // registers and loop state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q   <= '0;
      kp_q       <= '0;
      ki_q       <= '0;
      kd_q       <= '0;
      ilim_q     <= '1;
      deadband_q <= '0;
      fast_q     <= 16'd1;
      slow_q     <= 16'd1;
      int_q      <= '0;
      prev_q     <= '0;
      pulse_q    <= psd_pkg::MaxPulse;
      ramp_q     <= 1'b0;
      enabled_q  <= 1'b0;
      arrive_q   <= '0;
      reached_q  <= 1'b0;
    end else begin
      if (cfg_fire) begin
        case (psd_pkg::cfg_idx_e'(cfg_index_i))
          psd_pkg::CfgTarget: begin
            target_q  <= cfg_data_i[9:0];
            int_q     <= '0;
            arrive_q  <= '0;
            reached_q <= 1'b0;
          end
          psd_pkg::CfgKp:       kp_q       <= cfg_data_i[15:0];
          psd_pkg::CfgKi:       ki_q       <= cfg_data_i[15:0];
          psd_pkg::CfgKd:       kd_q       <= cfg_data_i[15:0];
          psd_pkg::CfgIntLimit: ilim_q     <= cfg_data_i;
          psd_pkg::CfgDeadband: deadband_q <= cfg_data_i[9:0];
          psd_pkg::CfgFastMin:  fast_q     <= cfg_data_i[15:0];
          psd_pkg::CfgSlowMin:  slow_q     <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      case (state_q)
        psd_pkg::StPrep: begin
          int_q  <= int_clamped;
          prev_q <= e_q;
        end
        psd_pkg::StCheck: begin
          if (!db_q && acc_q != '0) begin
            arrive_q <= '0;
          end
        end
        psd_pkg::StStep: begin
          if (out_free && !blocked) begin
            pulse_q   <= pulse_nx;
            ramp_q    <= dir_q;
            enabled_q <= 1'b1;
          end
        end
        psd_pkg::StOne: begin
          if (out_free && db_q) begin
            enabled_q <= 1'b0;
            int_q     <= '0;
            arrive_q  <= arrive_nx;
            reached_q <= reached_nx;
          end
        end
        default: ;
      endcase
    end
  end

  // working registers of the current sample
  always_ff @(posedge clk_i) begin
    case (state_q)
      psd_pkg::StIdle: begin
        if (in_fire) begin
          sample_q <= sample_in;
          e_q      <= e_in;
        end
      end
      psd_pkg::StPrep: begin
        delta_q <= 12'(e_q) - 12'(prev_q);
        big_q   <= (ae > psd_pkg::BigError);
        db_q    <= (ae <= deadband_q);
        if (ae > psd_pkg::BigError) begin
          pg_q <= {1'b0, kp_q, 4'd0} + {3'd0, kp_q, 2'd0};
          ig_q <= {ki_q, 1'b0};
          dg_q <= {({2'd0, kd_q} + {1'b0, kd_q, 1'b0}), 1'b0};
        end else begin
          pg_q <= {4'd0, kp_q, 1'b0};
          ig_q <= '0;
          dg_q <= {1'b0, ({2'd0, kd_q} + {1'b0, kd_q, 1'b0})};
        end
      end
      psd_pkg::StMulI:  acc_q <= prod_q[AccW-1:0];
      psd_pkg::StMulD:  acc_q <= acc_q + prod_q[AccW-1:0];
      psd_pkg::StSum:   acc_q <= acc_q + prod_q[AccW-1:0];
      psd_pkg::StCheck: begin
        // sign of a nonzero control value
        dir_q  <= acc_q[AccW-1];
        usat_q <= u_sat;
        k_q    <= '0;
      end
      psd_pkg::StSpeed: s_q <= usat_q ? psd_pkg::SpeedMax : prod_q[18:9];
      psd_pkg::StAbs: begin
        neg_q <= prod_q[ProdW-1];
        m_q   <= prod_q[ProdW-1] ? 26'(-prod_q) : prod_q[25:0];
      end
      psd_pkg::StTarget: tgt_q <= tgt_s[15:0];
      psd_pkg::StStep:   if (out_free) k_q <= k_q + 3'd1;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  logic out_load;
  assign out_load = out_free &&
                    (state_q == psd_pkg::StStep || state_q == psd_pkg::StOne);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (state_q == psd_pkg::StStep) begin
        olast_q  <= is_last;
        odir_q   <= dir_q;
        oreach_q <= reached_q;
        if (blocked) begin
          fired_q <= 1'b0;
          high_q  <= '0;
          low_q   <= '0;
          oen_q   <= enabled_q;
        end else begin
          fired_q <= 1'b1;
          high_q  <= pulse_nx;
          low_q   <= is_last ? 16'd0 : pulse_nx;
          oen_q   <= 1'b1;
        end
      end else begin
        // single result: deadband or zero control
        olast_q  <= 1'b1;
        odir_q   <= ramp_q;
        fired_q  <= 1'b0;
        high_q   <= '0;
        low_q    <= '0;
        oen_q    <= db_q ? 1'b0 : enabled_q;
        oreach_q <= db_q ? reached_nx : reached_q;
      end
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pid stepper position drive: an in-bench copy of
// the control loop predicts the step results of every accepted sample, and
// each result on the output stream is compared against the oldest prediction
// while both stream sides idle at random and the registers are retuned per phase.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned ReportMax  = 10;
  localparam int unsigned TailWait   = 40;
  localparam int unsigned IdlePct    = 21;

  typedef struct packed {
    logic        fired;
    logic [15:0] high_t;
    logic [15:0] low_t;
    logic        dir;
    logic        enable;
    logic        reached;
    logic        last;
  } step_res_t;

  // loop state and register copy, advanced once per accepted sample
  class stepper_loop;
    logic        [9:0]  target;
    logic        [15:0] kp, ki, kd;
    logic        [19:0] int_limit;
    logic        [9:0]  deadband;
    logic        [15:0] fast_min, slow_min;

    logic signed [21:0] integ;
    logic signed [10:0] last_err;
    logic        [15:0] period;
    logic               ramp_dir;
    logic               enabled;
    logic        [2:0]  arrive;
    logic               reached;

    step_res_t   due_steps[$];
    int unsigned mismatches;

    function new();
      target = '0; kp = '0; ki = '0; kd = '0;
      int_limit = 20'hFFFFF; deadband = '0;
      fast_min = 16'd1; slow_min = 16'd1;
      integ = '0; last_err = '0; period = psd_pkg::MaxPulse;
      ramp_dir = 1'b0; enabled = 1'b0; arrive = '0; reached = 1'b0;
      mismatches = 0;
    endfunction

    function void write_reg(psd_pkg::cfg_idx_e idx, logic [19:0] val);
      case (idx)
        psd_pkg::CfgTarget: begin
          target  = val[9:0];
          integ   = '0;
          arrive  = '0;
          reached = 1'b0;
        end
        psd_pkg::CfgKp:       kp        = val[15:0];
        psd_pkg::CfgKi:       ki        = val[15:0];
        psd_pkg::CfgKd:       kd        = val[15:0];
        psd_pkg::CfgIntLimit: int_limit = val;
        psd_pkg::CfgDeadband: deadband  = val[9:0];
        psd_pkg::CfgFastMin:  fast_min  = val[15:0];
        psd_pkg::CfgSlowMin:  slow_min  = val[15:0];
        default: ;
      endcase
    endfunction

    function void add_step(logic fired, logic [15:0] hi, logic [15:0] lo, logic dir,
                           logic last);
      step_res_t r;
      r.fired   = fired;
      r.high_t  = hi;
      r.low_t   = lo;
      r.dir     = dir;
      r.enable  = enabled;
      r.reached = reached;
      r.last    = last;
      due_steps.push_back(r);
    endfunction

    function void take_sample(logic [9:0] raw);
      longint smp, err, mag, delta, acc, lim, pg, ig, dg, u, mag_u, spd, minp, goal, nxt;
      logic   dir;
      logic   last;
      smp   = longint'(raw & psd_pkg::SampleMask);
      err   = longint'(target) - smp;
      mag   = (err < 0) ? -err : err;
      delta = err - longint'(last_err);
      lim   = longint'(int_limit);
      acc   = longint'(integ) + err;
      if (acc > lim) acc = lim;
      else if (acc < -lim) acc = -lim;
      integ = 22'(acc);

      // gain schedule in Q.9: large errors get the fast set
      if (mag > longint'(psd_pkg::BigError)) begin
        pg = longint'(kp) * 20; ig = longint'(ki) * 2; dg = longint'(kd) * 6;
        minp = longint'(fast_min);
      end else begin
        pg = longint'(kp) * 2; ig = 0; dg = longint'(kd) * 3;
        minp = longint'(slow_min);
      end
      u = pg * err + ig * longint'(integ) + dg * delta;
      last_err = 11'(err);

      if (u != 0 && mag > longint'(deadband)) begin
        dir   = (u > 0) ? 1'b0 : 1'b1;
        mag_u = (u < 0) ? -u : u;
        spd   = mag_u * 5000;
        spd   = (spd >= 512000) ? 1000 : spd / 512;
        goal  = longint'(psd_pkg::MaxPulse) +
                (spd * (minp - longint'(psd_pkg::MaxPulse))) / 1000;
        arrive = '0;
        for (int k = 0; k <= int'(psd_pkg::LastStep); k++) begin
          last = (k == int'(psd_pkg::LastStep));
          if ((smp < longint'(psd_pkg::LowLimit) && dir) ||
              (smp > longint'(psd_pkg::HighLimit) && !dir)) begin
            add_step(1'b0, '0, '0, dir, last);
          end else begin
            if (dir == ramp_dir) begin
              if (longint'(period) < goal) begin
                nxt    = longint'(period) + longint'(psd_pkg::Accel);
                period = 16'((nxt < goal) ? nxt : goal);
              end else if (longint'(period) > goal) begin
                nxt    = longint'(period) - longint'(psd_pkg::Accel);
                period = 16'((nxt > goal) ? nxt : goal);
              end
            end else begin
              // reversal restarts the ramp from the slowest pulse
              ramp_dir = dir;
              period   = psd_pkg::MaxPulse;
            end
            enabled = 1'b1;
            add_step(1'b1, period, last ? 16'd0 : period, dir, last);
          end
        end
      end else begin
        if (mag <= longint'(deadband)) begin
          enabled = 1'b0;
          integ   = '0;
          if (arrive < psd_pkg::ArriveNeeded) arrive = arrive + 3'd1;
          if (!reached && arrive >= psd_pkg::ArriveNeeded) reached = 1'b1;
        end
        add_step(1'b0, '0, '0, ramp_dir, 1'b1);
      end
    endfunction

    function void note_miss(string what, logic [15:0] want, logic [15:0] got);
      mismatches++;
      if (mismatches <= ReportMax)
        $display("step mismatch on %s: expected %0d, got %0d", what, want, got);
    endfunction

    function void match_step(logic fired, logic [39:0] data, logic last);
      step_res_t want;
      if (due_steps.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("step result with no sample behind it: tdata %h", data);
        return;
      end
      want = due_steps.pop_front();
      if (fired !== want.fired)
        note_miss("step_fired", 16'(want.fired), 16'(fired));
      if (data[15:0] !== want.high_t)   note_miss("high_time", want.high_t, data[15:0]);
      if (data[31:16] !== want.low_t)   note_miss("low_time", want.low_t, data[31:16]);
      if (data[32] !== want.dir)
        note_miss("move_dir", 16'(want.dir), 16'(data[32]));
      if (data[33] !== want.enable)
        note_miss("motor_enable", 16'(want.enable), 16'(data[33]));
      if (data[34] !== want.reached)
        note_miss("target_reached", 16'(want.reached), 16'(data[34]));
      if (last !== want.last)
        note_miss("tlast", 16'(want.last), 16'(last));
    endfunction

    function int unsigned pending();
      return due_steps.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i   = '0;
  logic [19:0] cfg_data_i    = '0;

  stepper_loop plant;
  bit          no_gaps = 1'b0;
  int unsigned samples_sent = 0;
  int unsigned idle_ticks = 0;

  pid_stepper_position_drive DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= no_gaps || ($urandom_range(99) >= IdlePct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      plant.match_step(m_axis_tuser[0], m_axis_tdata, m_axis_tlast);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_ticks <= 0;
    end else if (idle_ticks >= StallLimit) begin
      $display("tb_top: errors");
      $finish;
    end else begin
      idle_ticks <= idle_ticks + 1;
    end
  end

  // valid stays high between back-to-back requests
  task automatic send_sample(input logic [9:0] smp);
    while (!no_gaps && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, smp};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    plant.take_sample(smp);
    samples_sent++;
  endtask

  task automatic set_reg(input psd_pkg::cfg_idx_e idx, input logic [19:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    plant.write_reg(idx, val);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (plant.pending() != 0);
  endtask

  function automatic logic [19:0] pick_value(psd_pkg::cfg_idx_e idx);
    int unsigned roll;
    roll = $urandom_range(99);
    case (idx)
      psd_pkg::CfgTarget: begin
        if (roll < 10) return 20'd0;
        if (roll < 20) return 20'd1023;
        return 20'($urandom_range(1023));
      end
      psd_pkg::CfgIntLimit: begin
        if (roll < 12) return 20'd0;
        if (roll < 24) return 20'hFFFFF;
        if (roll < 70) return 20'($urandom_range(1, 2000));
        return 20'($urandom_range(20'hFFFFF));
      end
      psd_pkg::CfgDeadband: begin
        if (roll < 8) return 20'd1023;
        if (roll < 50) return 20'($urandom_range(3));
        if (roll < 90) return 20'($urandom_range(40));
        return 20'($urandom_range(1023));
      end
      psd_pkg::CfgFastMin, psd_pkg::CfgSlowMin: begin
        if (roll < 8) return 20'd0;
        if (roll < 16) return 20'd65535;
        if (roll < 24) return 20'd1;
        return 20'($urandom_range(1, 3000));
      end
      default: begin
        // gains: mostly small so the speed does not always saturate
        if (roll < 10) return 20'd0;
        if (roll < 18) return 20'd65535;
        if (roll < 70) return 20'($urandom_range(1, 48));
        return 20'($urandom_range(65535));
      end
    endcase
  endfunction

  task automatic retune();
    psd_pkg::cfg_idx_e idx;
    bit                wrote;
    wrote = 1'b0;
    idx   = idx.first();
    do begin
      if ($urandom_range(99) < ((idx == psd_pkg::CfgTarget) ? 70 : 60)) begin
        set_reg(idx, pick_value(idx));
        wrote = 1'b1;
      end
      idx = idx.next();
    end while (idx != idx.first());
    if (wrote) cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [9:0] near_target();
    int db, pos;
    db  = int'(plant.deadband);
    if (db > 60) db = 60;
    pos = int'(plant.target) + int'($urandom_range(2 * db)) - db;
    // now and then shift by db + 1, which can land just outside the band
    if ($urandom_range(99) < 15) pos += ($urandom_range(1) ? 1 : -1) * (db + 1);
    if (pos < 0) pos = 0;
    if (pos > 1023) pos = 1023;
    return 10'(pos);
  endfunction

  // mostly approach runs ending in the deadband, the rest scattered samples
  task automatic run_phase(input int unsigned count);
    int unsigned stop_at;
    int          start, goal, n;
    stop_at = samples_sent + count;
    while (samples_sent < stop_at) begin
      if ($urandom_range(99) < 70) begin
        start = int'($urandom_range(1023));
        goal  = int'(plant.target);
        n     = int'($urandom_range(2, 8));
        for (int i = 0; i < n; i++) send_sample(10'(start + (goal - start) * i / n));
        n = int'($urandom_range(4, 7));
        for (int i = 0; i < n; i++) send_sample(near_target());
      end else begin
        n = int'($urandom_range(1, 6));
        for (int i = 0; i < n; i++) send_sample(10'($urandom_range(1023)));
      end
    end
  endtask

  initial begin
    int unsigned ph;
    plant = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // register defaults: deadband hit, then zero control far from target
    send_sample(10'd0);
    send_sample(10'd1023);
    send_sample(10'd0);
    settle();

    set_reg(psd_pkg::CfgTarget, 20'd512);
    set_reg(psd_pkg::CfgKp, 20'd256);
    set_reg(psd_pkg::CfgKi, 20'd8);
    set_reg(psd_pkg::CfgKd, 20'd32);
    set_reg(psd_pkg::CfgIntLimit, 20'd100);
    set_reg(psd_pkg::CfgDeadband, 20'd2);
    set_reg(psd_pkg::CfgFastMin, 20'd0);
    set_reg(psd_pkg::CfgSlowMin, 20'd300);
    cfg_valid_i <= 1'b0;
    // far moves both ways, the large-error boundary, then settling to arrival
    send_sample(10'd0);
    send_sample(10'd1023);
    send_sample(10'd481);
    send_sample(10'd482);
    send_sample(10'd542);
    send_sample(10'd543);
    send_sample(10'd514);
    send_sample(10'd510);
    send_sample(10'd512);
    send_sample(10'd512);
    send_sample(10'd512);
    send_sample(10'd515);
    settle();

    set_reg(psd_pkg::CfgTarget, 20'd1023);
    set_reg(psd_pkg::CfgKp, 20'd65535);
    set_reg(psd_pkg::CfgKi, 20'd65535);
    set_reg(psd_pkg::CfgKd, 20'd65535);
    set_reg(psd_pkg::CfgIntLimit, 20'hFFFFF);
    set_reg(psd_pkg::CfgDeadband, 20'd0);
    set_reg(psd_pkg::CfgFastMin, 20'd65535);
    set_reg(psd_pkg::CfgSlowMin, 20'd1);
    cfg_valid_i <= 1'b0;
    send_sample(10'd0);
    send_sample(10'd0);
    send_sample(10'd1023);
    send_sample(10'd1022);

    ph = 0;
    while (samples_sent < 320) begin
      settle();
      no_gaps = (ph == 3 || ph == 4);
      retune();
      run_phase(32);
      ph++;
    end
    no_gaps = 1'b0;
    settle();
    repeat (TailWait) @(posedge clk_i);

    if (plant.mismatches == 0 && plant.pending() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ----- pid_stepper_position_drive.f -----
rtl/psd_pkg.sv
rtl/pid_stepper_position_drive.sv
tb/sv/tb_top.sv
